/* src/flpte_pkg.sv */
// ----------------------------------------------------------------------------
// flpte_pkg
// Shared types and constants for the four-level page table engine: store
// geometry, operation and status codes, sequencer states, memory request.
// ----------------------------------------------------------------------------
package flpte_pkg;

   localparam int TABLE_FRAMES = 16;
   localparam int ENTRIES      = 512;
   localparam int IDX_W        = $clog2(ENTRIES);
   localparam int FRAME_W      = $clog2(TABLE_FRAMES);
   localparam int NFF_W        = $clog2(TABLE_FRAMES + 1);
   localparam int STORE_DEPTH  = TABLE_FRAMES * ENTRIES;
   localparam int STORE_AW     = FRAME_W + IDX_W;
   localparam int PAGE_SHIFT   = 12;
   localparam int PA_W         = 52;
   localparam int VA_W         = 48;
   localparam int PG_W         = PA_W - PAGE_SHIFT;
   localparam int ENTRY_W      = 64;
   localparam int LVL_L4_SHIFT = 39;
   localparam int LVL_L3_SHIFT = 30;
   localparam int LVL_L2_SHIFT = 21;
   localparam int LVL_L1_SHIFT = 12;

   localparam int BIT_PRESENT = 0;
   localparam int BIT_WRITE   = 1;
   localparam int BIT_USER    = 2;

   typedef enum logic [1:0] {
      OP_TRANSLATE = 2'd0,
      OP_READ      = 2'd1,
      OP_MAP       = 2'd2,
      OP_UNMAP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_UNMAPPED = 2'd1,
      ST_NO_FRAME = 2'd2,
      ST_BAD_PTR  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_ZERO,
      S_LINK,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      LVL_PML4 = 2'd0,
      LVL_PDPT = 2'd1,
      LVL_PD   = 2'd2,
      LVL_PT   = 2'd3
   } level_type;

   typedef struct packed {
      logic                 we;
      logic [STORE_AW-1:0]  waddr;
      logic [ENTRY_W-1:0]   wdata;
      logic [STORE_AW-1:0]  raddr;
   } mem_req_type;

endpackage

/* src/flpte_store.sv */
// ----------------------------------------------------------------------------
// flpte_store
// Table frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module flpte_store
   import flpte_pkg::*;
(
   input  logic                clock,
   input  mem_req_type         mem_req,
   output logic [ENTRY_W-1:0]  rd_data
);

   logic [ENTRY_W-1:0] store_ff [STORE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= store_ff[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/four_level_page_table_engine.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_engine
// Walks and edits four-level page tables held in a local frame store.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation (translate, read leaf, map, unmap) on a
//   virtual address; rsp_* returns one result per request. Both channels
//   transfer on valid and ready high. csr_wr_en writes table_base (frame 0
//   address) and must only be used while the engine is idle.
//   Steps: a walk through existing levels has one evaluate state per level,
//   a table read before each of the lower three levels (the root read goes
//   out on the transfer edge), then the response state. Each level that
//   map creates adds a clear of the new 512-entry frame, then the link write.
//   One request is in flight at a time; req_ready is low during a walk, so
//   the next request transfers once the last result is loaded for output.
//   Reset: a clearing sweep zeroes the whole store, all TABLE_FRAMES*512
//   entries, with req_ready low. Configuration writes are taken.
//   Stall: the result sits in the output register until rsp_ready; a new
//   request may be taken meanwhile, and its walk holds in the response
//   cycle until the output register frees.
// ----------------------------------------------------------------------------
module four_level_page_table_engine
   import flpte_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [VA_W-1:0]     req_virt_addr,
   input  logic [PA_W-1:0]     req_phys_addr,
   input  logic [ENTRY_W-1:0]  req_page_flags,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [PA_W-1:0]     rsp_result_addr,
   output logic [ENTRY_W-1:0]  rsp_entry_value,
   input  logic                csr_wr_en,
   input  logic [PA_W-1:0]     csr_wr_data
);

   state_type            state_ff, state_in;
   level_type            lvl_ff, lvl_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   op_type               op_ff, op_in;
   logic [VA_W-1:0]      va_ff, va_in;
   logic [PG_W-1:0]      pa_pg_ff, pa_pg_in;
   logic [ENTRY_W-1:0]   flags_ff, flags_in;
   logic [PG_W-1:0]      base_pg_ff;
   logic [NFF_W-1:0]     nff_ff, nff_in;
   logic [STORE_AW-1:0]  cnt_ff, cnt_in;
   logic [STORE_AW-1:0]  slot_ff, slot_in;
   logic [FRAME_W-1:0]   newf_ff, newf_in;
   status_type           status_ff, status_in;
   logic [PA_W-1:0]      raddr_ff, raddr_in;
   logic [ENTRY_W-1:0]   entry_ff, entry_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [PA_W-1:0]      rsp_result_addr_ff, rsp_result_addr_in;
   logic [ENTRY_W-1:0]   rsp_entry_value_ff, rsp_entry_value_in;

   mem_req_type          mem_req;
   logic [ENTRY_W-1:0]   rd_data;

   logic                 req_xfer;
   logic                 rsp_load;
   logic                 create;
   logic                 present;
   logic                 leaf;
   logic                 bad_ptr;
   logic                 pool_empty;
   logic                 zero_done;
   logic                 clear_done;
   logic [IDX_W-1:0]     cur_idx;
   logic [STORE_AW-1:0]  cur_slot;

   // shared page-number adder: pointer-minus-base on walk, base-plus-frame on link
   logic [PG_W-1:0]      add_a, add_b, add_sum;
   logic                 add_sub;

   flpte_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      unique case (lvl_ff)
         LVL_PML4: cur_idx = va_ff[LVL_L4_SHIFT +: IDX_W];
         LVL_PDPT: cur_idx = va_ff[LVL_L3_SHIFT +: IDX_W];
         LVL_PD:   cur_idx = va_ff[LVL_L2_SHIFT +: IDX_W];
         LVL_PT:   cur_idx = va_ff[LVL_L1_SHIFT +: IDX_W];
         default:  cur_idx = va_ff[LVL_L1_SHIFT +: IDX_W];
      endcase
   end

   assign cur_slot   = {frame_ff, cur_idx};
   assign req_xfer   = req_valid && req_ready;
   assign rsp_load   = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);
   assign create     = (op_ff == OP_MAP);
   assign present    = rd_data[BIT_PRESENT];
   assign leaf       = (lvl_ff == LVL_PT);
   assign pool_empty = (nff_ff >= NFF_W'(TABLE_FRAMES));
   assign zero_done  = &cnt_ff[IDX_W-1:0];
   assign clear_done = (cnt_ff == STORE_AW'(STORE_DEPTH - 1));
   assign bad_ptr    = (add_sum >= PG_W'(TABLE_FRAMES));

   always_comb begin
      if (state_ff == S_LINK) begin
         add_a   = base_pg_ff;
         add_b   = PG_W'(newf_ff);
         add_sub = 1'b0;
      end else begin
         add_a   = rd_data[PA_W-1:PAGE_SHIFT];
         add_b   = base_pg_ff;
         add_sub = 1'b1;
      end
      add_sum = add_a + (add_sub ? ~add_b : add_b) + PG_W'(add_sub);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clear_done) state_in = S_IDLE;
         S_IDLE:  if (req_xfer) state_in = S_EVAL;
         S_READ:  state_in = S_EVAL;
         S_EVAL: begin
            if (leaf) begin
               state_in = S_RESP;
            end else if (present) begin
               state_in = bad_ptr ? S_RESP : S_READ;
            end else if (!create || pool_empty) begin
               state_in = S_RESP;
            end else begin
               state_in = S_ZERO;
            end
         end
         S_ZERO:  if (zero_done) state_in = S_LINK;
         S_LINK:  state_in = S_READ;
         S_RESP:  if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      mem_req.we    = 1'b0;
      mem_req.waddr = cur_slot;
      mem_req.wdata = '0;
      mem_req.raddr = cur_slot;
      lvl_in        = lvl_ff;
      frame_in      = frame_ff;
      op_in         = op_ff;
      va_in         = va_ff;
      pa_pg_in      = pa_pg_ff;
      flags_in      = flags_ff;
      nff_in        = nff_ff;
      cnt_in        = cnt_ff;
      slot_in       = slot_ff;
      newf_in       = newf_ff;
      status_in     = status_ff;
      raddr_in      = raddr_ff;
      entry_in      = entry_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = cnt_ff;
            cnt_in        = cnt_ff + STORE_AW'(1);
         end
         S_IDLE: begin
            // root read goes out on the transfer edge
            mem_req.raddr = {FRAME_W'(0), req_virt_addr[LVL_L4_SHIFT +: IDX_W]};
            if (req_xfer) begin
               lvl_in    = LVL_PML4;
               frame_in  = '0;
               op_in     = op_type'(req_op);
               va_in     = req_virt_addr;
               pa_pg_in  = req_phys_addr[PA_W-1:PAGE_SHIFT];
               flags_in  = req_page_flags;
               status_in = ST_OK;
               raddr_in  = '0;
               entry_in  = '0;
            end
         end
         S_READ: begin
         end
         S_EVAL: begin
            if (leaf) begin
               unique case (op_ff)
                  OP_TRANSLATE: begin
                     if (present) begin
                        raddr_in = {rd_data[PA_W-1:PAGE_SHIFT], va_ff[PAGE_SHIFT-1:0]};
                     end else begin
                        status_in = ST_UNMAPPED;
                     end
                  end
                  OP_READ: entry_in = rd_data;
                  OP_MAP: begin
                     mem_req.we    = 1'b1;
                     mem_req.wdata = {{(ENTRY_W-PA_W){1'b0}}, pa_pg_ff, {PAGE_SHIFT{1'b0}}}
                                     | flags_ff | ENTRY_W'(1);
                  end
                  OP_UNMAP: mem_req.we = 1'b1;
                  default: begin
                  end
               endcase
            end else if (present) begin
               // map with user flag marks every upper entry it passes
               mem_req.we    = create && flags_ff[BIT_USER];
               mem_req.wdata = rd_data | (ENTRY_W'(1) << BIT_USER);
               if (bad_ptr) begin
                  status_in = ST_BAD_PTR;
               end else begin
                  frame_in = add_sum[FRAME_W-1:0];
                  lvl_in   = level_type'(lvl_ff + 2'd1);
               end
            end else if (!create) begin
               status_in = ST_UNMAPPED;
            end else if (pool_empty) begin
               status_in = ST_NO_FRAME;
            end else begin
               newf_in = nff_ff[FRAME_W-1:0];
               nff_in  = nff_ff + NFF_W'(1);
               slot_in = cur_slot;
               cnt_in  = '0;
            end
         end
         S_ZERO: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = {newf_ff, cnt_ff[IDX_W-1:0]};
            cnt_in        = cnt_ff + STORE_AW'(1);
         end
         S_LINK: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = slot_ff;
            mem_req.wdata = {{(ENTRY_W-PA_W){1'b0}}, add_sum, {PAGE_SHIFT{1'b0}}};
            mem_req.wdata[BIT_PRESENT] = 1'b1;
            mem_req.wdata[BIT_WRITE]   = 1'b1;
            mem_req.wdata[BIT_USER]    = flags_ff[BIT_USER];
            frame_in = newf_ff;
            lvl_in   = level_type'(lvl_ff + 2'd1);
         end
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_status_in      = rsp_status_ff;
      rsp_result_addr_in = rsp_result_addr_ff;
      rsp_entry_value_in = rsp_entry_value_ff;
      if (rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_status_in      = status_ff;
         rsp_result_addr_in = raddr_ff;
         rsp_entry_value_in = entry_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         nff_ff       <= NFF_W'(1);
         cnt_ff       <= '0;
         base_pg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         lvl_ff       <= LVL_PML4;
      end else begin
         state_ff     <= state_in;
         nff_ff       <= nff_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         lvl_ff       <= lvl_in;
         if (csr_wr_en) begin
            base_pg_ff <= csr_wr_data[PA_W-1:PAGE_SHIFT];
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_ff           <= frame_in;
      op_ff              <= op_in;
      va_ff              <= va_in;
      pa_pg_ff           <= pa_pg_in;
      flags_ff           <= flags_in;
      slot_ff            <= slot_in;
      newf_ff            <= newf_in;
      status_ff          <= status_in;
      raddr_ff           <= raddr_in;
      entry_ff           <= entry_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_result_addr_ff <= rsp_result_addr_in;
      rsp_entry_value_ff <= rsp_entry_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_result_addr_ff;
   assign rsp_entry_value = rsp_entry_value_ff;

endmodule

/* src/flpte_checker.sv */
// ----------------------------------------------------------------------------
// flpte_checker
// Port-level checks for the page table engine, bound to the top level.
// ----------------------------------------------------------------------------
module flpte_checker
   import flpte_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [1:0]          rsp_status,
   input  logic [PA_W-1:0]     rsp_result_addr,
   input  logic [ENTRY_W-1:0]  rsp_entry_value
);

   // store sweep keeps requests out right after reset
   a_reset_not_ready: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or response right after reset");

   // one walk at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a walk is running");

   // address and entry fields are only filled on success
   a_fields_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_result_addr == '0
                                             && rsp_entry_value == '0)
      else $error("nonzero payload on error status");

   // a response never carries both an address and an entry
   a_addr_or_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_addr == '0 || rsp_entry_value == '0)
      else $error("response carries both address and entry");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_result_addr)
                                  && $stable(rsp_entry_value))
      else $error("stalled response changed");

endmodule

bind four_level_page_table_engine flpte_checker u_flpte_checker (.*);

/* tb/four_level_page_table_engine_tb.sv */
// ----------------------------------------------------------------------------
// four_level_page_table_engine_tb
// Self-checking bench for the page table engine. A scoreboard keeps its own
// copy of the frame store, the frame allocator and table_base, predicts
// each walk as requests transfer and compares each response field by field.
// Directed walks come first, then random phases under several table bases.
// ----------------------------------------------------------------------------
module four_level_page_table_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import flpte_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int END_SETTLE     = 24;
   localparam int MAX_REPORTS    = 40;

   typedef struct packed {
      status_type           status;
      logic [PA_W-1:0]      addr;
      logic [ENTRY_W-1:0]   entry;
   } walk_result_type;

   typedef enum int {
      RX_STEADY,
      RX_COIN,
      RX_BURSTY,
      RX_MOSTLY
   } ready_pattern_type;

   class walk_scoreboard;
      bit [ENTRY_W-1:0]  tables [STORE_DEPTH];
      int unsigned       next_free;
      bit [PA_W-1:0]     table_base;
      walk_result_type   awaited[$];
      int unsigned       errors;
      int unsigned       results_checked;
      int unsigned       op_count [4];
      int unsigned       status_count [4];

      function new();
         next_free  = 1;
         table_base = '0;
      endfunction

      function void set_table_base(bit [PA_W-1:0] value);
         table_base = value;
      endfunction

      function bit [PA_W-1:0] aligned_base();
         return {table_base[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
      endfunction

      // Follow or create one upper entry; child is the next frame on ST_OK.
      function status_type descend_level(int unsigned frame, bit [IDX_W-1:0] idx,
                                         bit create, bit [ENTRY_W-1:0] flags,
                                         output int unsigned child);
         int unsigned      slot;
         int unsigned      fresh;
         bit [ENTRY_W-1:0] pte;
         bit [PA_W-1:0]    offset;
         bit [PA_W-1:0]    fresh_addr;
         slot  = frame * ENTRIES + idx;
         pte   = tables[slot];
         child = 0;
         if (pte[BIT_PRESENT]) begin
            if (create && flags[BIT_USER]) begin
               pte[BIT_USER] = 1'b1;
               tables[slot]  = pte;
            end
            // distance from frame 0, modulo 2^52
            offset = {pte[PA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} - aligned_base();
            if (offset[PA_W-1:PAGE_SHIFT] >= TABLE_FRAMES)
               return ST_BAD_PTR;
            child = 32'(offset[PA_W-1:PAGE_SHIFT]);
            return ST_OK;
         end
         if (!create)
            return ST_UNMAPPED;
         if (next_free >= TABLE_FRAMES)
            return ST_NO_FRAME;
         fresh = next_free;
         next_free++;
         for (int i = 0; i < ENTRIES; i++)
            tables[fresh * ENTRIES + i] = '0;
         fresh_addr       = PA_W'(fresh);
         fresh_addr       = aligned_base() + (fresh_addr << PAGE_SHIFT);
         pte              = '0;
         pte[PA_W-1:0]    = fresh_addr;
         pte[BIT_PRESENT] = 1'b1;
         pte[BIT_WRITE]   = 1'b1;
         pte[BIT_USER]    = flags[BIT_USER];
         tables[slot]     = pte;
         child            = fresh;
         return ST_OK;
      endfunction

      function void note_request(op_type op, bit [VA_W-1:0] va, bit [PA_W-1:0] pa,
                                 bit [ENTRY_W-1:0] flags);
         walk_result_type  res;
         int unsigned      frame;
         int unsigned      child;
         int unsigned      leaf_slot;
         int               lvl;
         int               shift;
         bit [ENTRY_W-1:0] leaf;
         res.status = ST_OK;
         res.addr   = '0;
         res.entry  = '0;
         frame      = 0;
         for (lvl = 0; lvl < 3 && res.status == ST_OK; lvl++) begin
            case (lvl)
               0:       shift = LVL_L4_SHIFT;
               1:       shift = LVL_L3_SHIFT;
               default: shift = LVL_L2_SHIFT;
            endcase
            res.status = descend_level(frame, va[shift +: IDX_W], op == OP_MAP, flags, child);
            frame      = child;
         end
         if (res.status == ST_OK) begin
            leaf_slot = frame * ENTRIES + va[LVL_L1_SHIFT +: IDX_W];
            leaf      = tables[leaf_slot];
            case (op)
               OP_TRANSLATE: begin
                  if (leaf[BIT_PRESENT])
                     res.addr = {leaf[PA_W-1:PAGE_SHIFT], va[PAGE_SHIFT-1:0]};
                  else
                     res.status = ST_UNMAPPED;
               end
               OP_READ: res.entry = leaf;
               OP_MAP: begin
                  leaf = flags;
                  leaf[PA_W-1:PAGE_SHIFT] = leaf[PA_W-1:PAGE_SHIFT] | pa[PA_W-1:PAGE_SHIFT];
                  leaf[BIT_PRESENT] = 1'b1;
                  tables[leaf_slot] = leaf;
               end
               default: tables[leaf_slot] = '0;
            endcase
         end
         op_count[op]++;
         status_count[res.status]++;
         awaited.push_back(res);
      endfunction

      task report_mismatch(string what, logic [ENTRY_W-1:0] got, logic [ENTRY_W-1:0] want);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("[%0t] result %0d: %s is %h, expected %h",
                     $time, results_checked, what, got, want);
      endtask

      task check_result(logic [1:0] status, logic [PA_W-1:0] addr, logic [ENTRY_W-1:0] entry);
         walk_result_type want;
         results_checked++;
         if (awaited.size() == 0) begin
            report_mismatch("result with nothing outstanding, status",
                            ENTRY_W'(status), '0);
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status)
            report_mismatch("status", ENTRY_W'(status), ENTRY_W'(want.status));
         if (addr !== want.addr)
            report_mismatch("result_addr", ENTRY_W'(addr), ENTRY_W'(want.addr));
         if (entry !== want.entry)
            report_mismatch("entry_value", entry, want.entry);
      endtask
   endclass

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [1:0]          req_op          = OP_TRANSLATE;
   logic [VA_W-1:0]     req_virt_addr   = '0;
   logic [PA_W-1:0]     req_phys_addr   = '0;
   logic [ENTRY_W-1:0]  req_page_flags  = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [1:0]          rsp_status;
   logic [PA_W-1:0]     rsp_result_addr;
   logic [ENTRY_W-1:0]  rsp_entry_value;
   logic                csr_wr_en       = 1'b0;
   logic [PA_W-1:0]     csr_wr_data     = '0;

   walk_scoreboard      board;
   int unsigned         burst_left      = 1;
   int unsigned         base_writes     = 0;
   int unsigned         idle_cycles     = 0;
   int unsigned         rsp_tick        = 0;
   ready_pattern_type   rsp_mode        = RX_STEADY;

   four_level_page_table_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_virt_addr   (req_virt_addr),
      .req_phys_addr   (req_phys_addr),
      .req_page_flags  (req_page_flags),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_result_addr (rsp_result_addr),
      .rsp_entry_value (rsp_entry_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Receiver: switches between stall patterns every so often.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_status, rsp_result_addr, rsp_entry_value);
      rsp_tick++;
      if (rsp_tick % 192 == 0)
         rsp_mode = ready_pattern_type'($urandom_range(0, 3));
      case (rsp_mode)
         RX_STEADY: rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
         RX_BURSTY: rsp_ready <= ((rsp_tick % 16) >= 12);
         default:   rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   function automatic logic [VA_W-1:0] make_va(logic [IDX_W-1:0] l4, l3, l2, l1,
                                               logic [PAGE_SHIFT-1:0] offset);
      return {l4, l3, l2, l1, offset};
   endfunction

   // Caller is at a rising edge. Returns at the edge of the transfer, or
   // after the idle gap that ends a burst.
   task automatic send_request(op_type op, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                               logic [ENTRY_W-1:0] flags);
      int unsigned gap;
      req_valid      <= 1'b1;
      req_op         <= op;
      req_virt_addr  <= va;
      req_phys_addr  <= pa;
      req_page_flags <= flags;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      board.note_request(op, va, pa, flags);
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (board.awaited.size() != 0);
   endtask

   task automatic change_table_base(logic [PA_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_table_base(value);
      base_writes++;
   endtask

   task automatic run_random_phase(logic [PA_W-1:0] base, int unsigned count);
      logic [63:0]         rand64;
      logic [ENTRY_W-1:0]  flags;
      logic [VA_W-1:0]     va;
      logic [IDX_W-1:0]    l4, l3, l2, l1;
      int unsigned         roll;
      op_type              op;
      change_table_base(base);
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 30)
            op = OP_TRANSLATE;
         else if (roll < 55)
            op = OP_READ;
         else if (roll < 80)
            op = OP_MAP;
         else
            op = OP_UNMAP;

         // mostly walks along paths that exist, some elsewhere
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            case ($urandom_range(0, 4))
               0:       {l4, l3, l2} = {9'd0, 9'd0, 9'd0};
               1:       {l4, l3, l2} = {9'd511, 9'd511, 9'd511};
               2:       {l4, l3, l2} = {9'h155, 9'd0, 9'd0};
               3:       {l4, l3, l2} = {9'h155, 9'd1, 9'd0};
               default: {l4, l3, l2} = {9'h0AA, 9'd0, 9'd0};
            endcase
         end else begin
            case ($urandom_range(0, 5))
               0:       l4 = 9'd0;
               1:       l4 = 9'd511;
               2:       l4 = 9'h155;
               3:       l4 = 9'h0AA;
               4:       l4 = 9'h0AB;
               default: l4 = IDX_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0:       l3 = 9'd0;
               1:       l3 = 9'd1;
               2:       l3 = 9'd511;
               default: l3 = IDX_W'($urandom);
            endcase
            case ($urandom_range(0, 2))
               0:       l2 = 9'd0;
               1:       l2 = 9'd511;
               default: l2 = IDX_W'($urandom);
            endcase
         end
         if ($urandom_range(0, 3) == 0)
            l1 = IDX_W'($urandom);
         else if ($urandom_range(0, 8) == 0)
            l1 = 9'd511;
         else
            l1 = IDX_W'($urandom_range(0, 7));
         va = make_va(l4, l3, l2, l1, PAGE_SHIFT'($urandom));
         if (roll >= 90) begin
            rand64 = {$urandom, $urandom};
            va     = rand64[VA_W-1:0];
         end

         rand64 = {$urandom, $urandom};
         if ($urandom_range(0, 9) < 7)
            flags = {rand64[63], 51'b0, rand64[11:0]};
         else
            flags = rand64;

         if ($urandom_range(0, 149) == 0)
            drain();
         rand64 = {$urandom, $urandom};
         send_request(op, va, rand64[PA_W-1:0], flags);
      end
   endtask

   initial begin
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // root empty after reset, table_base 0
      send_request(OP_TRANSLATE, '0, '0, '0);
      send_request(OP_READ, '1, '0, '0);
      send_request(OP_UNMAP, 48'h1234_5678_9ABC, '0, '0);
      send_request(OP_MAP, '0, '1, '0);
      send_request(OP_TRANSLATE, 48'h0000_0000_0FFF, '0, '0);
      send_request(OP_READ, '0, '0, '0);
      send_request(OP_MAP, '1, '0, '1);
      send_request(OP_READ, '1, '0, '0);
      send_request(OP_TRANSLATE, '1, '0, '0);
      // user map through existing upper levels
      send_request(OP_MAP, 48'h0000_0000_1000, 52'hA_BCDE_F012_3456, 64'h8000_0000_0000_0004);
      send_request(OP_TRANSLATE, 48'h0000_0000_1ABC, '0, '0);
      // levels present, leaf absent
      send_request(OP_READ, 48'h0000_0000_2000, '0, '0);
      send_request(OP_TRANSLATE, 48'h0000_0000_2000, '0, '0);
      send_request(OP_UNMAP, 48'h0000_0000_2000, '0, '0);
      send_request(OP_UNMAP, '0, '0, '0);
      send_request(OP_TRANSLATE, '0, '0, '0);

      // top base: new frame addresses wrap past 2^52
      change_table_base('1);
      send_request(OP_TRANSLATE, 48'h0000_0000_1000, '0, '0);
      send_request(OP_MAP, make_va(9'h0AA, 9'd0, 9'd0, 9'd3, 12'h000),
                   52'h5_5555_5555_5000, 64'h0000_0000_0000_0006);
      send_request(OP_TRANSLATE, make_va(9'h0AA, 9'd0, 9'd0, 9'd3, 12'h123), '0, '0);

      // existing pointers now fall below frame 0
      change_table_base(52'h0_0000_0000_5000);
      send_request(OP_TRANSLATE, 48'h0000_0000_1000, '0, '0);
      send_request(OP_MAP, 48'h0000_0000_1000, 52'h0_0000_0000_7000, 64'h4);

      // use up the frame pool, last map stops halfway down
      change_table_base('0);
      send_request(OP_MAP, make_va(9'h155, 9'd0, 9'd0, 9'd0, 12'h0), 52'h1_0000_0000_0000, 64'h7);
      send_request(OP_MAP, make_va(9'h155, 9'd1, 9'd0, 9'd0, 12'h0), 52'h2_0000_0000_0000, 64'h3);
      send_request(OP_MAP, make_va(9'h0AB, 9'd0, 9'd0, 9'd0, 12'h0), 52'h3_0000_0000_0000, 64'h1);
      send_request(OP_MAP, make_va(9'h0AB, 9'd0, 9'd0, 9'd1, 12'h0), 52'h4_0000_0000_0000, 64'h5);

      run_random_phase('0, 500);
      run_random_phase('1, 150);
      run_random_phase(PA_W'({$urandom, $urandom}), 100);
      run_random_phase(52'h0_0000_0000_1000, 100);
      run_random_phase('0, 550);

      drain();
      repeat (END_SETTLE) @(posedge clock);

      $display("Covered %0d walks (%0d translate, %0d read, %0d map, %0d unmap)",
               board.results_checked, board.op_count[OP_TRANSLATE], board.op_count[OP_READ],
               board.op_count[OP_MAP], board.op_count[OP_UNMAP]);
      $display("Outcomes over %0d base writes: %0d ok, %0d not mapped, %0d pool empty, %0d bad pointer; %0d mismatches",
               base_writes, board.status_count[ST_OK], board.status_count[ST_UNMAPPED],
               board.status_count[ST_NO_FRAME], board.status_count[ST_BAD_PTR], board.errors);
      if (board.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
